/* sv/mos_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mos_pkg - shared types and constants for the move ordering scorer
// Table geometry, score constants, piece values, command codes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mos_pkg;

    // Table geometry
    localparam int PLY_LEVELS   = 64;
    localparam int SQUARE_COUNT = 64;
    localparam int PIECE_CODES  = 14;

    localparam int HIST_DEPTH = SQUARE_COUNT * PIECE_CODES;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int HIST_W     = 20;
    localparam int KILL_AW    = (PLY_LEVELS > 2) ? $clog2(PLY_LEVELS) : 1;
    localparam int MOVE_W     = 32;
    localparam int SCORE_W    = 22;
    localparam int SLOT_W     = HIST_AW;
    localparam int PLY_EXT_W  = 9;

    // Scores and limits
    localparam logic [SCORE_W-1:0] SCORE_HASH    = 22'd3000000;
    localparam logic [SCORE_W-1:0] SCORE_CAPTURE = 22'd2000000;
    localparam logic [SCORE_W-1:0] SCORE_KILLER  = 22'd1000000;
    localparam logic [HIST_W-1:0]  HIST_LIMIT    = 20'd1000000;

    typedef enum logic [1:0] {
        MODE_SCORE  = 2'd0,
        MODE_UPDATE = 2'd1,
        MODE_KILLER = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCORE,
        ST_UPDATE,
        ST_HALVE,
        ST_HALVE_TAIL,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic accept;     // item transfer: latch fields, issue table reads
        logic kill_wr;    // store killer for the item's ply
        logic tbl_clr;    // drop killer valid bits and the peak
        logic score_fire; // register the score and pulse done
        logic upd_write;  // write back the updated history entry
        logic halve_rd;   // sweep: read entry for halving
        logic clear_wr;   // sweep: write zero
    } ctrl_cmd_t;

    typedef struct packed {
        logic over_limit; // updated entry exceeds the history limit
        logic sweep_last; // sweep counter at the last entry
    } dp_status_t;

    function automatic logic [14:0] piece_value(input logic [3:0] code);
        logic [14:0] v;
        unique case (code) inside
            4'd2, 4'd3:               v = 15'd100;
            4'd4, 4'd5, 4'd6, 4'd7:   v = 15'd400;
            4'd8, 4'd9:               v = 15'd600;
            4'd10, 4'd11:             v = 15'd1200;
            4'd12, 4'd13:             v = 15'd20000;
            default:                  v = 15'd0;
        endcase
        return v;
    endfunction

endpackage

/* sv/mos_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mos_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/mos_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mos_ctrl - sequencing for the move ordering scorer
// Decodes the command of each transfer and steps through table read,
// write-back, halving sweep and clearing sweep.
// ----------------------------------------------------------------------------
module mos_ctrl
    import mos_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] mode,
    input  dp_status_t sts,
    output logic       busy,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    mode_t  mode_in;
    logic   accept;

    assign mode_in = mode_t'(mode);
    assign accept  = start && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR; // clearing pass after reset
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode_in)
                        MODE_SCORE:  state_next = ST_SCORE;
                        MODE_UPDATE: state_next = ST_UPDATE;
                        MODE_KILLER: state_next = ST_IDLE;
                        MODE_CLEAR:  state_next = ST_CLEAR;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCORE:      state_next = ST_IDLE;
            ST_UPDATE:     state_next = sts.over_limit ? ST_HALVE : ST_IDLE;
            ST_HALVE:      state_next = sts.sweep_last ? ST_HALVE_TAIL : ST_HALVE;
            ST_HALVE_TAIL: state_next = ST_IDLE;
            ST_CLEAR:      state_next = sts.sweep_last ? ST_IDLE : ST_CLEAR;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy           = (state_reg != ST_IDLE);
        cmd            = '0;
        cmd.accept     = accept;
        cmd.kill_wr    = accept && (mode_in == MODE_KILLER);
        cmd.tbl_clr    = accept && (mode_in == MODE_CLEAR);
        cmd.score_fire = (state_reg == ST_SCORE);
        cmd.upd_write  = (state_reg == ST_UPDATE);
        cmd.halve_rd   = (state_reg == ST_HALVE);
        cmd.clear_wr   = (state_reg == ST_CLEAR);
    end

    // A halving sweep runs to its last entry once started
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HALVE && !sts.sweep_last) |=> (state_reg == ST_HALVE))
        else $error("halving sweep left early");

endmodule

/* sv/mos_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mos_datapath - tables and arithmetic of the move ordering scorer
// History RAM with sweep counter, killer RAM with valid bits, score select,
// saturating history update and the running peak.
// ----------------------------------------------------------------------------
module mos_datapath
    import mos_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         sts,
    input  logic [MOVE_W-1:0]  move_code,
    input  logic [5:0]         to_square,
    input  logic [3:0]         moving_piece,
    input  logic [3:0]         captured_piece,
    input  logic [3:0]         promotion_piece,
    input  logic [MOVE_W-1:0]  hash_move,
    input  logic [5:0]         ply_level,
    input  logic [5:0]         search_depth,
    output logic               done,
    output logic [SCORE_W-1:0] sort_score
);

    // Address decode of the incoming item
    logic [SLOT_W-1:0]    slot_raw;
    logic                 acc_slot_ok;
    logic [HIST_AW-1:0]   acc_slot;
    logic [PLY_EXT_W-1:0] ply_ext;
    logic                 acc_ply_ok;
    logic [KILL_AW-1:0]   kidx;
    logic [15:0]          vsum;
    logic [19:0]          vsum_x10;
    logic [SCORE_W-1:0]   acc_capt_score;

    assign slot_raw    = SLOT_W'(to_square) * SLOT_W'(PIECE_CODES) + SLOT_W'(moving_piece);
    assign acc_slot_ok = {1'b0, moving_piece} < 5'(PIECE_CODES);
    assign acc_slot    = acc_slot_ok ? slot_raw[HIST_AW-1:0] : '0;
    assign ply_ext     = PLY_EXT_W'(ply_level);
    assign acc_ply_ok  = ply_ext < PLY_EXT_W'(PLY_LEVELS);
    assign kidx        = ply_ext[KILL_AW-1:0];

    assign vsum           = 16'(piece_value(captured_piece)) + 16'(piece_value(promotion_piece));
    assign vsum_x10       = (20'(vsum) << 3) + (20'(vsum) << 1);
    assign acc_capt_score = SCORE_CAPTURE + SCORE_W'(vsum_x10)
                            - SCORE_W'(piece_value(moving_piece));

    // Item fields registered at the transfer
    logic [MOVE_W-1:0]  mv_reg;
    logic               hash_hit_reg;
    logic               capt_reg;
    logic [SCORE_W-1:0] capt_score_reg;
    logic [HIST_AW-1:0] slot_reg;
    logic               slot_ok_reg;
    logic               ply_ok_reg;
    logic               kv_reg;
    logic [5:0]         depth_reg;

    // Killer valid bits
    logic [PLY_LEVELS-1:0] kvalid_reg;
    logic [PLY_LEVELS-1:0] kvalid_next;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mv_reg         <= move_code;
            hash_hit_reg   <= (hash_move != '0) && (move_code == hash_move);
            capt_reg       <= (captured_piece != 4'd0) || (promotion_piece != 4'd0);
            capt_score_reg <= acc_capt_score;
            slot_reg       <= acc_slot;
            slot_ok_reg    <= acc_slot_ok;
            ply_ok_reg     <= acc_ply_ok;
            kv_reg         <= kvalid_reg[kidx];
            depth_reg      <= search_depth;
        end
    end

    always_comb
    begin
        kvalid_next = kvalid_reg;
        if (cmd.tbl_clr)
        begin
            kvalid_next = '0;
        end
        else if (cmd.kill_wr && acc_ply_ok)
        begin
            kvalid_next[kidx] = 1'b1;
        end
    end

    // Sweep counter and halving write-back pipeline
    logic [HIST_AW-1:0] cnt_reg;
    logic [HIST_AW-1:0] cnt_next;
    logic               pend_reg;
    logic [HIST_AW-1:0] pend_addr_reg;
    logic               sweep_step;
    logic               sweep_last;

    assign sweep_step = cmd.halve_rd || cmd.clear_wr;
    assign sweep_last = (cnt_reg == HIST_AW'(HIST_DEPTH - 1));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (sweep_step)
        begin
            cnt_next = sweep_last ? '0 : cnt_reg + HIST_AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= cnt_reg;
    end

    // History RAM
    logic               hist_we;
    logic [HIST_AW-1:0] hist_waddr;
    logic [HIST_W-1:0]  hist_wdata;
    logic               hist_re;
    logic [HIST_AW-1:0] hist_raddr;
    logic [HIST_W-1:0]  hist_rdata;
    logic [HIST_W:0]    upd_sum;
    logic [HIST_W-1:0]  upd_val;
    logic               over;

    assign upd_sum = {1'b0, hist_rdata} + (HIST_W + 1)'(depth_reg);
    assign upd_val = upd_sum[HIST_W] ? '1 : upd_sum[HIST_W-1:0];
    assign over    = slot_ok_reg && (upd_val > HIST_LIMIT);

    always_comb
    begin
        hist_we    = 1'b0;
        hist_waddr = cnt_reg;
        hist_wdata = '0;
        if (cmd.clear_wr)
        begin
            hist_we = 1'b1;
        end
        else if (cmd.upd_write && slot_ok_reg)
        begin
            hist_we    = 1'b1;
            hist_waddr = slot_reg;
            hist_wdata = upd_val;
        end
        else if (pend_reg)
        begin
            // write back the entry read in the previous cycle, halved
            hist_we    = 1'b1;
            hist_waddr = pend_addr_reg;
            hist_wdata = hist_rdata >> 1;
        end
    end

    assign hist_re    = cmd.accept || cmd.halve_rd;
    assign hist_raddr = cmd.halve_rd ? cnt_reg : acc_slot;

    mos_ram #(
        .WIDTH (HIST_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // Killer RAM
    logic [MOVE_W-1:0] kill_rdata;

    mos_ram #(
        .WIDTH (MOVE_W),
        .DEPTH (PLY_LEVELS)
    ) u_kill_ram (
        .clk   (clk),
        .we    (cmd.kill_wr && acc_ply_ok),
        .waddr (kidx),
        .wdata (move_code),
        .re    (cmd.accept),
        .raddr (kidx),
        .rdata (kill_rdata)
    );

    // History peak
    logic [HIST_W-1:0] peak_reg;
    logic [HIST_W-1:0] peak_next;
    logic [HIST_W-1:0] peak_max;

    assign peak_max = (upd_val > peak_reg) ? upd_val : peak_reg;

    always_comb
    begin
        peak_next = peak_reg;
        if (cmd.tbl_clr)
        begin
            peak_next = '0;
        end
        else if (cmd.upd_write && slot_ok_reg)
        begin
            peak_next = over ? (peak_max >> 1) : peak_max;
        end
    end

    // Score select
    logic               kill_hit;
    logic [SCORE_W-1:0] score_next;
    logic [SCORE_W-1:0] score_reg;
    logic               done_reg;

    assign kill_hit = ply_ok_reg && kv_reg && (kill_rdata != '0) && (kill_rdata == mv_reg);

    always_comb
    begin
        if (hash_hit_reg)
        begin
            score_next = SCORE_HASH;
        end
        else if (capt_reg)
        begin
            score_next = capt_score_reg;
        end
        else if (kill_hit)
        begin
            score_next = SCORE_KILLER;
        end
        else if (slot_ok_reg)
        begin
            score_next = SCORE_W'(hist_rdata);
        end
        else
        begin
            score_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.score_fire)
        begin
            score_reg <= score_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kvalid_reg <= '0;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            peak_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            kvalid_reg <= kvalid_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= cmd.halve_rd;
            peak_reg   <= peak_next;
            done_reg   <= cmd.score_fire;
        end
    end

    assign sts.over_limit = over;
    assign sts.sweep_last = sweep_last;
    assign done           = done_reg;
    assign sort_score     = score_reg;

endmodule

/* sv/move_order_scorer_history.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_order_scorer_history - move ordering engine for game-tree search
// Scores moves by hash move, capture value, killer and history heuristic;
// maintains the history table (with halving) and one killer per ply.
//
//   channel  | signals                                        | transfer
//   ---------+------------------------------------------------+-----------------
//   command  | mode, move_code, to_square, moving_piece,      | start && !busy
//            | captured_piece, promotion_piece, hash_move,    |
//            | ply_level, search_depth                        |
//   result   | sort_score                                     | done, one cycle
//
// Score: transfer cycle, then history/killer RAM read; done pulses in the first
//   cycle with busy low.
// History update: an entry above the limit adds a halving sweep, one
//   read-modify-write per cycle over the 896-entry RAM.
// Killer store: written in the transfer cycle. Clear: one history entry per cycle.
// After reset, busy stays high for the clearing pass of the history
// RAM. The result side cannot stall; done is never held.
// ----------------------------------------------------------------------------
module move_order_scorer_history
    import mos_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [MOVE_W-1:0]  move_code,
    input  logic [5:0]         to_square,
    input  logic [3:0]         moving_piece,
    input  logic [3:0]         captured_piece,
    input  logic [3:0]         promotion_piece,
    input  logic [MOVE_W-1:0]  hash_move,
    input  logic [5:0]         ply_level,
    input  logic [5:0]         search_depth,
    output logic               done,
    output logic [SCORE_W-1:0] sort_score
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    mos_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    mos_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .move_code       (move_code),
        .to_square       (to_square),
        .moving_piece    (moving_piece),
        .captured_piece  (captured_piece),
        .promotion_piece (promotion_piece),
        .hash_move       (hash_move),
        .ply_level       (ply_level),
        .search_depth    (search_depth),
        .done            (done),
        .sort_score      (sort_score)
    );

    // A score command yields its result through the ST_SCORE state and the done register
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_SCORE) |=> ##1 done)
        else $error("score result missing");

    // Other commands yield no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode != MODE_SCORE) |=> ##1 !done)
        else $error("unexpected result");

    // A result only follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work");

endmodule

/* tb/tb_move_order_scorer_history.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_move_order_scorer_history - self-checking bench for the move ordering scorer
// Drives score, history update, killer store and clear commands through the
// start/busy handshake and checks every sort_score against a behavioral copy
// of the history table, history peak and killer slots. A directed table covers
// the hash, capture, killer and history rules and their corner cases. Random
// traffic biased toward a few hot squares, pieces and plies follows.
// ----------------------------------------------------------------------------
module tb_move_order_scorer_history;
    import mos_pkg::*;

    localparam int unsigned PTS_HASH    = 3000000;
    localparam int unsigned PTS_CAPTURE = 2000000;
    localparam int unsigned PTS_KILLER  = 1000000;
    localparam int unsigned HIST_CAP    = 1000000;
    localparam int          HIST_SAT    = 20'hFFFFF;
    localparam int          MAX_REPORTS = 10;
    localparam int          DRAIN_LIMIT = 5000;
    localparam int          SETTLE_CYC  = 1000;

    typedef enum int { HIT_HASH, HIT_CAPTURE, HIT_KILLER, HIT_HISTORY } hit_kind_t;

    typedef struct {
        mode_t              op;
        logic [MOVE_W-1:0]  mv;
        logic [5:0]         sq;
        logic [3:0]         mover;
        logic [3:0]         victim;
        logic [3:0]         promo;
        logic [MOVE_W-1:0]  hmv;
        logic [5:0]         ply;
        logic [5:0]         depth;
        bit                 typed;
        logic [SCORE_W-1:0] score;
    } cmd_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         mode;
    logic [MOVE_W-1:0]  move_code;
    logic [5:0]         to_square;
    logic [3:0]         moving_piece;
    logic [3:0]         captured_piece;
    logic [3:0]         promotion_piece;
    logic [MOVE_W-1:0]  hash_move;
    logic [5:0]         ply_level;
    logic [5:0]         search_depth;
    logic               done;
    logic [SCORE_W-1:0] sort_score;

    // shadow state of the scorer
    logic [HIST_W-1:0]  hist_tbl [HIST_DEPTH];
    logic [HIST_W-1:0]  hist_peak;
    logic [MOVE_W-1:0]  killer_move [PLY_LEVELS];

    logic [SCORE_W-1:0] score_due [$];
    logic [SCORE_W-1:0] score_want;
    cmd_row_t           directed [$];

    int                 fault_count = 0;
    int                 scores_seen = 0;
    int                 n_cmd [4] = '{0, 0, 0, 0};
    int                 hits [4] = '{0, 0, 0, 0};
    int                 n_halve = 0;
    int                 idle_odds = 0;

    logic [MOVE_W-1:0]  move_pool [8];
    logic [5:0]         hot_sq [4];
    logic [3:0]         hot_piece [3];
    logic [5:0]         hot_ply [4];

    move_order_scorer_history u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .move_code       (move_code),
        .to_square       (to_square),
        .moving_piece    (moving_piece),
        .captured_piece  (captured_piece),
        .promotion_piece (promotion_piece),
        .hash_move       (hash_move),
        .ply_level       (ply_level),
        .search_depth    (search_depth),
        .done            (done),
        .sort_score      (sort_score)
    );

    always #5 clk = ~clk;

    function automatic int unsigned piece_worth(input logic [3:0] code);
        case (code) inside
            4'd2, 4'd3:             return 100;
            4'd4, 4'd5, 4'd6, 4'd7: return 400;
            4'd8, 4'd9:             return 600;
            4'd10, 4'd11:           return 1200;
            4'd12, 4'd13:           return 20000;
            default:                return 0;
        endcase
    endfunction

    function automatic cmd_row_t row(input mode_t op, input logic [MOVE_W-1:0] mv,
                                     input logic [5:0] sq, input logic [3:0] mover,
                                     input logic [3:0] victim, input logic [3:0] promo,
                                     input logic [MOVE_W-1:0] hmv, input logic [5:0] ply,
                                     input logic [5:0] depth, input bit typed,
                                     input logic [SCORE_W-1:0] score);
        cmd_row_t c;
        c.op     = op;
        c.mv     = mv;
        c.sq     = sq;
        c.mover  = mover;
        c.victim = victim;
        c.promo  = promo;
        c.hmv    = hmv;
        c.ply    = ply;
        c.depth  = depth;
        c.typed  = typed;
        c.score  = score;
        return c;
    endfunction

    // Append one row to the directed table.
    function automatic void add_directed(input cmd_row_t c);
        directed = {directed, c};
    endfunction

    // Ordering score of one move against the current tables.
    function automatic logic [SCORE_W-1:0] rank_move(input cmd_row_t c, output int kind);
        int unsigned pts;
        pts = 0;
        if (c.hmv != '0 && c.mv == c.hmv)
        begin
            kind = HIT_HASH;
            pts  = PTS_HASH;
        end
        else if (c.victim != 4'd0 || c.promo != 4'd0)
        begin
            kind = HIT_CAPTURE;
            pts  = PTS_CAPTURE + 10 * (piece_worth(c.victim) + piece_worth(c.promo))
                   - piece_worth(c.mover);
        end
        else if (int'(c.ply) < PLY_LEVELS && killer_move[c.ply] != '0 &&
                 killer_move[c.ply] == c.mv)
        begin
            kind = HIT_KILLER;
            pts  = PTS_KILLER;
        end
        else
        begin
            kind = HIT_HISTORY;
            if (int'(c.mover) < PIECE_CODES)
                pts = hist_tbl[int'(c.sq) * PIECE_CODES + int'(c.mover)];
        end
        return pts[SCORE_W-1:0];
    endfunction

    function automatic void wipe_tables();
        foreach (hist_tbl[i])
            hist_tbl[i] = '0;
        foreach (killer_move[i])
            killer_move[i] = '0;
        hist_peak = '0;
    endfunction

    // Advance the shadow tables by one accepted command.
    function automatic void apply_command(input cmd_row_t c);
        int                 idx;
        int                 kind;
        int                 sum;
        logic [SCORE_W-1:0] pts;
        n_cmd[c.op]++;
        case (c.op)
            MODE_SCORE:
            begin
                pts = rank_move(c, kind);
                hits[kind]++;
                score_due = {score_due, (c.typed ? c.score : pts)};
            end
            MODE_UPDATE:
            begin
                if (int'(c.mover) < PIECE_CODES)
                begin
                    idx = int'(c.sq) * PIECE_CODES + int'(c.mover);
                    sum = int'(hist_tbl[idx]) + int'(c.depth);
                    if (sum > HIST_SAT)
                        sum = HIST_SAT;
                    hist_tbl[idx] = sum[HIST_W-1:0];
                    if (hist_tbl[idx] > hist_peak)
                        hist_peak = hist_tbl[idx];
                    if (sum > int'(HIST_CAP))
                    begin
                        hist_peak = hist_peak >> 1;
                        foreach (hist_tbl[i])
                            hist_tbl[i] = hist_tbl[i] >> 1;
                        n_halve++;
                    end
                end
            end
            MODE_KILLER:
            begin
                if (int'(c.ply) < PLY_LEVELS)
                    killer_move[c.ply] = c.mv;
            end
            default:
                wipe_tables();
        endcase
    endfunction

    // Random command biased toward a few hot moves, squares, pieces and plies
    // so that hash, killer and history hits show up often.
    function automatic cmd_row_t random_cmd();
        cmd_row_t c;
        int       r;
        r = $urandom_range(0, 99);
        c.op = (r < 48) ? MODE_SCORE : (r < 75) ? MODE_UPDATE :
               (r < 98) ? MODE_KILLER : MODE_CLEAR;
        c.mv = ($urandom_range(0, 3) == 0) ? $urandom() : move_pool[$urandom_range(0, 7)];
        r = $urandom_range(0, 9);
        c.hmv = (r < 3) ? c.mv : (r < 5) ? '0 :
                (r < 7) ? move_pool[$urandom_range(0, 7)] : $urandom();
        if ($urandom_range(0, 1) == 0)
        begin
            c.victim = 4'd0;
            c.promo  = 4'd0;
        end
        else
        begin
            c.victim = 4'($urandom_range(0, 15));
            c.promo  = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
        end
        c.sq    = ($urandom_range(0, 9) < 7) ? hot_sq[$urandom_range(0, 3)] :
                  6'($urandom_range(0, 63));
        c.mover = ($urandom_range(0, 9) < 7) ? hot_piece[$urandom_range(0, 2)] :
                  4'($urandom_range(0, 15));
        c.ply   = ($urandom_range(0, 9) < 7) ? hot_ply[$urandom_range(0, 3)] :
                  6'($urandom_range(0, 63));
        c.depth = 6'($urandom_range(0, 63));
        c.typed = 1'b0;
        c.score = '0;
        return c;
    endfunction

    // Present one command, hold it until the transfer, then update the shadow.
    task automatic issue(input cmd_row_t c);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        start           <= 1'b1;
        mode            <= c.op;
        move_code       <= c.mv;
        to_square       <= c.sq;
        moving_piece    <= c.mover;
        captured_piece  <= c.victim;
        promotion_piece <= c.promo;
        hash_move       <= c.hmv;
        ply_level       <= c.ply;
        search_depth    <= c.depth;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_command(c);
    endtask

    function automatic void log_fault(input string what);
        if (fault_count < MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, what);
        fault_count++;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (score_due.size() == 0)
                log_fault($sformatf("sort_score %0d with no score pending", sort_score));
            else
            begin
                score_want = score_due.pop_front();
                scores_seen++;
                if (sort_score !== score_want)
                    log_fault($sformatf("sort_score expected %0d, got %0d",
                                        score_want, sort_score));
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("move_order_scorer_history regression: fail");
        $finish;
    end

    initial
    begin
        int wait_cyc;

        rst_n           <= 1'b0;
        start           <= 1'b0;
        mode            <= MODE_SCORE;
        move_code       <= '0;
        to_square       <= '0;
        moving_piece    <= '0;
        captured_piece  <= '0;
        promotion_piece <= '0;
        hash_move       <= '0;
        ply_level       <= '0;
        search_depth    <= '0;
        wipe_tables();

        move_pool[0] = '0;
        move_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++)
            move_pool[i] = $urandom();
        hot_sq       = '{6'd0, 6'd63, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63))};
        hot_piece    = '{4'd13, 4'($urandom_range(0, 13)), 4'd0};
        hot_ply      = '{6'd0, 6'd63, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63))};

        //               op           mv            sq  mvr vic pro hmv      ply dep typed score
        add_directed(row(MODE_SCORE,  32'h0,        0,  0,  0,  0, 32'h0,        0, 0, 1, 0));
        add_directed(row(MODE_SCORE,  32'h12345678, 0,  0,  0,  0, 32'h12345678, 0, 0, 1,
                         3000000));
        add_directed(row(MODE_SCORE,  32'hFFFFFFFF, 0,  0, 13, 13, 32'hFFFFFFFF, 0, 0, 1,
                         3000000));
        add_directed(row(MODE_SCORE,  32'h1,        0,  0, 13, 13, 32'h2,        0, 0, 1,
                         2400000));
        add_directed(row(MODE_SCORE,  32'h1,        0, 13,  1,  0, 32'h0,        0, 0, 1,
                         1980000));
        add_directed(row(MODE_SCORE,  32'h1,        0,  2,  0, 10, 32'h0,        0, 0, 1,
                         2011900));
        // codes above the value table count as zero
        add_directed(row(MODE_SCORE,  32'h1,        0, 15, 15, 14, 32'h0,        0, 0, 1,
                         2000000));
        add_directed(row(MODE_KILLER, 32'h0,        0,  0,  0,  0, 32'h0,        0, 0, 0, 0));
        // a zero killer must not match a zero move
        add_directed(row(MODE_SCORE,  32'h0,        5,  3,  0,  0, 32'h0,        0, 0, 1, 0));
        add_directed(row(MODE_KILLER, 32'hDEADBEEF, 0,  0,  0,  0, 32'h0,       63, 0, 0, 0));
        add_directed(row(MODE_SCORE,  32'hDEADBEEF, 0,  0,  0,  0, 32'h0,       63, 0, 1,
                         1000000));
        add_directed(row(MODE_SCORE,  32'hDEADBEEF, 0,  0,  0,  0, 32'h0,       62, 0, 1, 0));
        add_directed(row(MODE_SCORE,  32'hDEADBEEF, 0, 12,  4,  0, 32'h0,       63, 0, 0, 0));
        add_directed(row(MODE_UPDATE, 32'h0,       63, 13,  0,  0, 32'h0,        0, 63, 0, 0));
        add_directed(row(MODE_UPDATE, 32'h0,       63, 13,  0,  0, 32'h0,        0, 63, 0, 0));
        add_directed(row(MODE_SCORE,  32'h7,       63, 13,  0,  0, 32'h0,        1, 0, 0, 0));
        // movers outside the history table neither read nor write it
        add_directed(row(MODE_UPDATE, 32'h0,       63, 15,  0,  0, 32'h0,        0, 63, 0, 0));
        add_directed(row(MODE_SCORE,  32'h7,       63, 15,  0,  0, 32'h0,        1, 0, 1, 0));
        add_directed(row(MODE_UPDATE, 32'h0,        0,  0,  0,  0, 32'h0,        0, 0, 0, 0));
        add_directed(row(MODE_UPDATE, 32'h0,        0,  0,  0,  0, 32'h0,        0, 1, 0, 0));
        add_directed(row(MODE_SCORE,  32'h7,        0,  0,  0,  0, 32'h0,        1, 0, 0, 0));
        add_directed(row(MODE_CLEAR,  32'h0,        0,  0,  0,  0, 32'h0,        0, 0, 0, 0));
        add_directed(row(MODE_SCORE,  32'h7,       63, 13,  0,  0, 32'h0,        1, 0, 1, 0));
        add_directed(row(MODE_SCORE,  32'hDEADBEEF, 0,  0,  0,  0, 32'h0,       63, 0, 1, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_odds = 4;
        foreach (directed[i])
            issue(directed[i]);

        idle_odds = 6;
        repeat (680)
            issue(random_cmd());

        // back-to-back tail
        idle_odds = 0;
        repeat (300)
            issue(random_cmd());
        start <= 1'b0;

        for (wait_cyc = 0; wait_cyc < DRAIN_LIMIT && score_due.size() != 0; wait_cyc++)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        if (score_due.size() != 0)
            log_fault($sformatf("%0d scores never arrived", score_due.size()));

        $display("Ran %0d scores (%0d hash, %0d capture, %0d killer, %0d history), %0d checked",
                 n_cmd[MODE_SCORE], hits[HIT_HASH], hits[HIT_CAPTURE], hits[HIT_KILLER],
                 hits[HIT_HISTORY], scores_seen);
        $display("plus %0d history updates with %0d halvings, %0d killer stores, %0d clears",
                 n_cmd[MODE_UPDATE], n_halve, n_cmd[MODE_KILLER], n_cmd[MODE_CLEAR]);
        if (fault_count == 0)
            $display("move_order_scorer_history regression: pass");
        else
            $display("move_order_scorer_history regression: fail");
        $finish;
    end

endmodule
